/* hw/rtl/mpm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mpm_pkg;

	localparam int CoordW    = 32;
	localparam int NormW     = 16;
	localparam int CornerW   = 16;
	localparam int IdxW      = 17;
	localparam int ModeW     = 2;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 32;
	localparam int FracShift = 14;
	localparam int HalfQ14   = 8192;
	localparam int MaxVertices = 65536;

	localparam int ProdW = CoordW + NormW;
	localparam int SumW  = ProdW + 2;
	localparam int DW    = SumW - FracShift;
	localparam int QW    = DW + NormW + 1;
	localparam int RW    = QW - FracShift;
	localparam int MW    = RW + 1;

	localparam logic [ModeW-1:0] ModeXy     = 2'd0;
	localparam logic [ModeW-1:0] ModeXz     = 2'd1;
	localparam logic [ModeW-1:0] ModeYz     = 2'd2;
	localparam logic [ModeW-1:0] ModeCustom = 2'd3;

	localparam logic [CfgIdxW-1:0] CfgPlaneMode   = 3'd0;
	localparam logic [CfgIdxW-1:0] CfgPlaneOffset = 3'd1;
	localparam logic [CfgIdxW-1:0] CfgNormalX     = 3'd2;
	localparam logic [CfgIdxW-1:0] CfgNormalY     = 3'd3;
	localparam logic [CfgIdxW-1:0] CfgNormalZ     = 3'd4;
	localparam logic [CfgIdxW-1:0] CfgEmitBoth    = 3'd5;
	localparam logic [CfgIdxW-1:0] CfgVertexTotal = 3'd6;

	localparam logic OpVertex = 1'b0;
	localparam logic OpFace   = 1'b1;

	localparam logic signed [NormW-1:0] NormUnit = 16'sd16384;

	typedef struct packed {
		logic [ModeW-1:0]         plane_mode;
		logic signed [CoordW-1:0] plane_offset;
		logic signed [NormW-1:0]  normal_x;
		logic signed [NormW-1:0]  normal_y;
		logic signed [NormW-1:0]  normal_z;
		logic                     emit_both;
		logic [IdxW-1:0]          vertex_total;
	} cfg_t;

	typedef struct packed {
		logic                     kind;
		logic signed [CoordW-1:0] vx;
		logic signed [CoordW-1:0] vy;
		logic signed [CoordW-1:0] vz;
		logic signed [CoordW-1:0] mx;
		logic signed [CoordW-1:0] my;
		logic signed [CoordW-1:0] mz;
		logic [CornerW-1:0]       ca;
		logic [CornerW-1:0]       cb;
		logic [CornerW-1:0]       cc;
	} mir_item_t;

	function automatic logic signed [CoordW-1:0] sat32(input logic signed [MW-1:0] x);
		logic signed [CoordW-1:0] r;
		if (x[MW-1] == 1'b0 && x[MW-2:CoordW-1] != '0) begin
			r = {1'b0, {(CoordW-1){1'b1}}};
		end else if (x[MW-1] == 1'b1 && x[MW-2:CoordW-1] != '1) begin
			r = {1'b1, {(CoordW-1){1'b0}}};
		end else begin
			r = x[CoordW-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/mpm_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none

interface mpm_item_if;
	import mpm_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     op;
	logic signed [CoordW-1:0] coord_x;
	logic signed [CoordW-1:0] coord_y;
	logic signed [CoordW-1:0] coord_z;
	logic [CornerW-1:0]       corner_a;
	logic [CornerW-1:0]       corner_b;
	logic [CornerW-1:0]       corner_c;

	modport source (output valid, op, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c,
		input ready);
	modport sink (input valid, op, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c,
		output ready);
endinterface

interface mpm_result_if;
	import mpm_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic                     is_mirror;
	logic signed [CoordW-1:0] res_x;
	logic signed [CoordW-1:0] res_y;
	logic signed [CoordW-1:0] res_z;
	logic [IdxW-1:0]          res_a;
	logic [IdxW-1:0]          res_b;
	logic [IdxW-1:0]          res_c;
	logic                     last;

	modport source (output valid, kind, is_mirror, res_x, res_y, res_z, res_a, res_b, res_c,
		last, input ready);
	modport sink (input valid, kind, is_mirror, res_x, res_y, res_z, res_a, res_b, res_c,
		last, output ready);
endinterface

interface mpm_cfg_if;
	import mpm_pkg::*;
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  idx;
	logic [CfgDataW-1:0] data;

	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mesh_plane_mirror.sv */
`timescale 1ns / 1ps
`default_nettype none

// Mesh plane mirror. Vertex beats are reflected across the XY, XZ or YZ plane
// or a custom plane (Q1.14 normal, Q16.16 offset) with results saturated to
// 32 bits; mirrored face beats get their second and third corners swapped and
// the clamped vertex total added if emit_both is set. An item enters every
// cycle, while not stalled from downstream, into a five-stage arithmetic
// pipeline (input register, dot-product multipliers, rounding sum, scale
// multipliers, round/subtract/saturate) followed by an output register. With
// emit_both set each item leaves as two result beats on the single output
// port, and the output register takes no new item until both have left; with
// emit_both clear it takes one item per cycle while results are ready.
// Configuration writes are always ready and must be issued only while no item is in flight.
module mesh_plane_mirror (
	input  wire          clk,
	input  wire          arst_n,
	mpm_item_if.sink     items,
	mpm_result_if.source results,
	mpm_cfg_if.sink      cfg
);
	import mpm_pkg::*;

	cfg_t      regs;
	logic      pipe_valid;
	logic      pipe_ready;
	mir_item_t pipe_item;

	mpm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	mpm_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.items     (items),
		.out_valid (pipe_valid),
		.out_ready (pipe_ready),
		.out_item  (pipe_item)
	);

	mpm_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.regs     (regs),
		.in_valid (pipe_valid),
		.in_ready (pipe_ready),
		.in_item  (pipe_item),
		.results  (results)
	);

endmodule

`default_nettype wire

/* hw/rtl/mpm_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module mpm_cfg (
	input  wire          clk,
	input  wire          arst_n,
	mpm_cfg_if.sink      cfg,
	output mpm_pkg::cfg_t regs
);
	import mpm_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.plane_mode   <= ModeXy;
			regs_q.plane_offset <= '0;
			regs_q.normal_x     <= '0;
			regs_q.normal_y     <= '0;
			regs_q.normal_z     <= NormUnit;
			regs_q.emit_both    <= 1'b1;
			regs_q.vertex_total <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.idx)
				CfgPlaneMode:   regs_q.plane_mode   <= cfg.data[ModeW-1:0];
				CfgPlaneOffset: regs_q.plane_offset <= cfg.data[CoordW-1:0];
				CfgNormalX:     regs_q.normal_x     <= cfg.data[NormW-1:0];
				CfgNormalY:     regs_q.normal_y     <= cfg.data[NormW-1:0];
				CfgNormalZ:     regs_q.normal_z     <= cfg.data[NormW-1:0];
				CfgEmitBoth:    regs_q.emit_both    <= cfg.data[0];
				CfgVertexTotal: regs_q.vertex_total <= cfg.data[IdxW-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/mpm_pipe.sv */
`timescale 1ns / 1ps
`default_nettype none

module mpm_pipe (
	input  wire               clk,
	input  wire               arst_n,
	input  mpm_pkg::cfg_t     regs,
	mpm_item_if.sink          items,
	output logic              out_valid,
	input  wire               out_ready,
	output mpm_pkg::mir_item_t out_item
);
	import mpm_pkg::*;

	logic signed [NormW-1:0]  n0, n1, n2;
	logic signed [CoordW-1:0] off;

	always_comb begin
		n0  = '0;
		n1  = '0;
		n2  = '0;
		off = '0;
		unique case (regs.plane_mode)
			ModeXy: n2 = NormUnit;
			ModeXz: n1 = NormUnit;
			ModeYz: n0 = NormUnit;
			default: begin
				n0  = regs.normal_x;
				n1  = regs.normal_y;
				n2  = regs.normal_z;
				off = regs.plane_offset;
			end
		endcase
	end

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en1, en2, en3, en4, en5;

	assign en5 = !vld_s5 || out_ready;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign items.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= items.valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
		end
	end

	logic                     op_s1, op_s2, op_s3, op_s4, op_s5;
	logic signed [CoordW-1:0] vx_s1, vy_s1, vz_s1;
	logic signed [CoordW-1:0] vx_s2, vy_s2, vz_s2;
	logic signed [CoordW-1:0] vx_s3, vy_s3, vz_s3;
	logic signed [CoordW-1:0] vx_s4, vy_s4, vz_s4;
	logic signed [CoordW-1:0] vx_s5, vy_s5, vz_s5;
	logic [3*CornerW-1:0]     cr_s1, cr_s2, cr_s3, cr_s4, cr_s5;
	logic signed [ProdW-1:0]  p0_s2, p1_s2, p2_s2;
	logic signed [SumW-1:0]   off14_s2;
	logic signed [DW-1:0]     d16_s3;
	logic signed [QW-1:0]     q0_s4, q1_s4, q2_s4;
	logic signed [CoordW-1:0] mx_s5, my_s5, mz_s5;

	logic signed [SumW-1:0] sum;
	logic signed [SumW-1:0] off_ext;
	logic signed [RW-1:0]   r0, r1, r2;

	assign off_ext = SumW'(off);
	assign sum = SumW'(p0_s2) + SumW'(p1_s2) + SumW'(p2_s2) - off14_s2
		+ SumW'(HalfQ14);
	assign r0 = RW'((q0_s4 + QW'(HalfQ14)) >>> FracShift);
	assign r1 = RW'((q1_s4 + QW'(HalfQ14)) >>> FracShift);
	assign r2 = RW'((q2_s4 + QW'(HalfQ14)) >>> FracShift);

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1 <= items.op;
			vx_s1 <= items.coord_x;
			vy_s1 <= items.coord_y;
			vz_s1 <= items.coord_z;
			cr_s1 <= {items.corner_a, items.corner_b, items.corner_c};
		end
		if (en2) begin
			op_s2    <= op_s1;
			vx_s2    <= vx_s1;
			vy_s2    <= vy_s1;
			vz_s2    <= vz_s1;
			cr_s2    <= cr_s1;
			p0_s2    <= ProdW'(vx_s1) * ProdW'(n0);
			p1_s2    <= ProdW'(vy_s1) * ProdW'(n1);
			p2_s2    <= ProdW'(vz_s1) * ProdW'(n2);
			off14_s2 <= off_ext <<< FracShift;
		end
		if (en3) begin
			op_s3  <= op_s2;
			vx_s3  <= vx_s2;
			vy_s3  <= vy_s2;
			vz_s3  <= vz_s2;
			cr_s3  <= cr_s2;
			d16_s3 <= DW'(sum >>> FracShift);
		end
		if (en4) begin
			op_s4 <= op_s3;
			vx_s4 <= vx_s3;
			vy_s4 <= vy_s3;
			vz_s4 <= vz_s3;
			cr_s4 <= cr_s3;
			q0_s4 <= (QW'(d16_s3) * QW'(n0)) <<< 1;
			q1_s4 <= (QW'(d16_s3) * QW'(n1)) <<< 1;
			q2_s4 <= (QW'(d16_s3) * QW'(n2)) <<< 1;
		end
		if (en5) begin
			op_s5 <= op_s4;
			vx_s5 <= vx_s4;
			vy_s5 <= vy_s4;
			vz_s5 <= vz_s4;
			cr_s5 <= cr_s4;
			mx_s5 <= sat32(MW'(vx_s4) - MW'(r0));
			my_s5 <= sat32(MW'(vy_s4) - MW'(r1));
			mz_s5 <= sat32(MW'(vz_s4) - MW'(r2));
		end
	end

	assign out_valid   = vld_s5;
	assign out_item.kind = op_s5;
	assign out_item.vx = vx_s5;
	assign out_item.vy = vy_s5;
	assign out_item.vz = vz_s5;
	assign out_item.mx = mx_s5;
	assign out_item.my = my_s5;
	assign out_item.mz = mz_s5;
	assign out_item.ca = cr_s5[3*CornerW-1:2*CornerW];
	assign out_item.cb = cr_s5[2*CornerW-1:CornerW];
	assign out_item.cc = cr_s5[CornerW-1:0];

endmodule

`default_nettype wire

/* hw/rtl/mpm_emit.sv */
`timescale 1ns / 1ps
`default_nettype none

module mpm_emit (
	input  wire                clk,
	input  wire                arst_n,
	input  mpm_pkg::cfg_t      regs,
	input  wire                in_valid,
	output logic               in_ready,
	input  mpm_pkg::mir_item_t in_item,
	mpm_result_if.source       results
);
	import mpm_pkg::*;

	mir_item_t held_q;
	logic      full_q;
	logic      second_q;

	logic            mirror;
	logic            take;
	logic            done;
	logic [IdxW-1:0] clamp;
	logic [IdxW-1:0] add;

	assign mirror   = !regs.emit_both || second_q;
	assign take     = full_q && results.ready;
	assign done     = take && mirror;
	assign in_ready = !full_q || done;

	assign clamp = (regs.vertex_total > IdxW'(MaxVertices)) ? IdxW'(MaxVertices)
		: regs.vertex_total;
	assign add   = regs.emit_both ? clamp : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q   <= 1'b0;
			second_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			full_q   <= 1'b1;
			second_q <= 1'b0;
		end else if (done) begin
			full_q   <= 1'b0;
		end else if (take) begin
			second_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) held_q <= in_item;
	end

	always_comb begin
		results.valid     = full_q;
		results.kind      = held_q.kind;
		results.is_mirror = mirror;
		results.last      = mirror;
		results.res_x     = '0;
		results.res_y     = '0;
		results.res_z     = '0;
		results.res_a     = '0;
		results.res_b     = '0;
		results.res_c     = '0;
		if (held_q.kind == OpVertex) begin
			results.res_x = mirror ? held_q.mx : held_q.vx;
			results.res_y = mirror ? held_q.my : held_q.vy;
			results.res_z = mirror ? held_q.mz : held_q.vz;
		end else if (mirror) begin
			results.res_a = IdxW'(held_q.ca) + add;
			results.res_b = IdxW'(held_q.cc) + add;
			results.res_c = IdxW'(held_q.cb) + add;
		end else begin
			results.res_a = IdxW'(held_q.ca);
			results.res_b = IdxW'(held_q.cb);
			results.res_c = IdxW'(held_q.cc);
		end
	end

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
	import mpm_pkg::*;

	localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;
	localparam int     SinkHoldCycles = 200;
	localparam longint SatHi = 64'sd2147483647;
	localparam longint SatLo = -64'sd2147483648;

	typedef struct packed {
		logic                     op;
		logic signed [CoordW-1:0] x, y, z;
		logic [CornerW-1:0]       a, b, c;
	} mesh_item_t;

	typedef struct packed {
		logic                     kind;
		logic                     is_mirror;
		logic signed [CoordW-1:0] x, y, z;
		logic [IdxW-1:0]          a, b, c;
		logic                     last;
	} mesh_beat_t;

	logic       clk;
	logic       arst_n;
	bit         idle_on;
	bit         sink_hold_req;
	int         fail_count;
	cfg_t       plane_cfg;
	mesh_beat_t pending_beats[$];

	mpm_item_if   item_bus();
	mpm_result_if result_bus();
	mpm_cfg_if    cfg_bus();

	mesh_plane_mirror dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(item_bus),
		.results(result_bus),
		.cfg(cfg_bus)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(10_000_000);
		$display("mesh_plane_mirror regression: fail");
		$finish;
	end

	function automatic void queue_beat(input mesh_beat_t b);
		pending_beats.insert(pending_beats.size(), b);
	endfunction

	function automatic void reflect_item(input mesh_item_t it);
		longint                   v[3];
		longint                   n[3];
		longint                   off;
		longint                   d30;
		longint                   d16;
		longint                   m;
		longint                   add;
		logic signed [CoordW-1:0] mc[3];
		mesh_beat_t               orig;
		mesh_beat_t               mir;
		orig = '0;
		mir = '0;
		orig.kind = it.op;
		mir.kind = it.op;
		mir.is_mirror = 1'b1;
		mir.last = 1'b1;
		if (it.op == OpVertex) begin
			v[0] = $signed(it.x);
			v[1] = $signed(it.y);
			v[2] = $signed(it.z);
			n[0] = 0;
			n[1] = 0;
			n[2] = 0;
			off = 0;
			case (plane_cfg.plane_mode)
				ModeXy: n[2] = NormUnit;
				ModeXz: n[1] = NormUnit;
				ModeYz: n[0] = NormUnit;
				default: begin
					n[0] = $signed(plane_cfg.normal_x);
					n[1] = $signed(plane_cfg.normal_y);
					n[2] = $signed(plane_cfg.normal_z);
					off = $signed(plane_cfg.plane_offset);
				end
			endcase
			d30 = v[0] * n[0] + v[1] * n[1] + v[2] * n[2] - (off <<< FracShift);
			d16 = (d30 + HalfQ14) >>> FracShift;
			for (int i = 0; i < 3; i++) begin
				m = v[i] - ((2 * d16 * n[i] + HalfQ14) >>> FracShift);
				if (m > SatHi) begin
					m = SatHi;
				end else if (m < SatLo) begin
					m = SatLo;
				end
				mc[i] = m[CoordW-1:0];
			end
			orig.x = it.x;
			orig.y = it.y;
			orig.z = it.z;
			mir.x = mc[0];
			mir.y = mc[1];
			mir.z = mc[2];
		end else begin
			add = 0;
			if (plane_cfg.emit_both) begin
				add = (plane_cfg.vertex_total > MaxVertices) ? MaxVertices : plane_cfg.vertex_total;
			end
			orig.a = {1'b0, it.a};
			orig.b = {1'b0, it.b};
			orig.c = {1'b0, it.c};
			mir.a = IdxW'(it.a + add);
			mir.b = IdxW'(it.c + add);
			mir.c = IdxW'(it.b + add);
		end
		if (plane_cfg.emit_both) begin
			queue_beat(orig);
		end
		queue_beat(mir);
	endfunction

	function automatic void check_field(input string name, input logic [CoordW-1:0] want,
		input logic [CoordW-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : check_beats
		mesh_beat_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_beats.size() == 0) begin
				$error("result beat with nothing pending");
				fail_count++;
			end else begin
				want = pending_beats.pop_front();
				check_field("kind", CoordW'(want.kind), CoordW'(result_bus.kind));
				check_field("is_mirror", CoordW'(want.is_mirror), CoordW'(result_bus.is_mirror));
				check_field("res_x", want.x, result_bus.res_x);
				check_field("res_y", want.y, result_bus.res_y);
				check_field("res_z", want.z, result_bus.res_z);
				check_field("res_a", CoordW'(want.a), CoordW'(result_bus.res_a));
				check_field("res_b", CoordW'(want.b), CoordW'(result_bus.res_b));
				check_field("res_c", CoordW'(want.c), CoordW'(result_bus.res_c));
				check_field("last", CoordW'(want.last), CoordW'(result_bus.last));
			end
		end
	end

	initial begin
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				result_bus.ready <= 1'b0;
				repeat (SinkHoldCycles) @(posedge clk);
				result_bus.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				result_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				result_bus.ready <= 1'b1;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	function automatic mesh_item_t vertex(input logic signed [CoordW-1:0] x, y, z);
		mesh_item_t it;
		it = '0;
		it.op = OpVertex;
		it.x = x;
		it.y = y;
		it.z = z;
		return it;
	endfunction

	function automatic mesh_item_t face(input logic [CornerW-1:0] a, b, c);
		mesh_item_t it;
		it = '0;
		it.op = OpFace;
		it.a = a;
		it.b = b;
		it.c = c;
		return it;
	endfunction

	function automatic logic signed [CoordW-1:0] random_coord();
		logic [CoordW-1:0] r;
		r = $urandom();
		case ($urandom_range(0, 5))
			0: r = {r[0], {(CoordW-1){~r[0]}}};
			1, 2: r = {{12{r[20]}}, r[19:0]};
			default: ;
		endcase
		return r;
	endfunction

	function automatic mesh_item_t random_item();
		mesh_item_t it;
		it.op = 1'($urandom_range(0, 1));
		it.x = random_coord();
		it.y = random_coord();
		it.z = random_coord();
		it.a = CornerW'($urandom_range(0, 65535));
		it.b = CornerW'($urandom_range(0, 65535));
		it.c = CornerW'($urandom_range(0, 65535));
		return it;
	endfunction

	task automatic send_item(input mesh_item_t it);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		item_bus.valid    <= 1'b1;
		item_bus.op       <= it.op;
		item_bus.coord_x  <= it.x;
		item_bus.coord_y  <= it.y;
		item_bus.coord_z  <= it.z;
		item_bus.corner_a <= it.a;
		item_bus.corner_b <= it.b;
		item_bus.corner_c <= it.c;
		do @(posedge clk); while (!item_bus.ready);
		reflect_item(it);
	endtask

	task automatic wait_idle();
		item_bus.valid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.idx   <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			CfgPlaneMode:   plane_cfg.plane_mode   = data[ModeW-1:0];
			CfgPlaneOffset: plane_cfg.plane_offset = data;
			CfgNormalX:     plane_cfg.normal_x     = data[NormW-1:0];
			CfgNormalY:     plane_cfg.normal_y     = data[NormW-1:0];
			CfgNormalZ:     plane_cfg.normal_z     = data[NormW-1:0];
			CfgEmitBoth:    plane_cfg.emit_both    = data[0];
			CfgVertexTotal: plane_cfg.vertex_total = data[IdxW-1:0];
			default: ;
		endcase
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [ModeW-1:0] mode, input logic signed [CoordW-1:0] offset,
		input logic signed [NormW-1:0] nx, ny, nz, input logic both, input logic [IdxW-1:0] total);
		logic [CfgDataW-1:0] junk;
		wait_idle();
		junk = $urandom();
		write_reg(CfgPlaneMode, {junk[CfgDataW-1:ModeW], mode});
		write_reg(CfgPlaneOffset, offset);
		write_reg(CfgNormalX, {junk[CfgDataW-1:NormW], nx});
		write_reg(CfgNormalY, {~junk[CfgDataW-1:NormW], ny});
		write_reg(CfgNormalZ, {junk[CfgDataW-1:NormW], nz});
		write_reg(CfgEmitBoth, {junk[CfgDataW-1:1], both});
		write_reg(CfgVertexTotal, {~junk[CfgDataW-1:IdxW], total});
	endtask

	task automatic random_plane();
		logic [ModeW-1:0]         mode;
		logic signed [CoordW-1:0] offset;
		logic signed [NormW-1:0]  nrm[3];
		logic [IdxW-1:0]          total;
		mode = ($urandom_range(0, 5) > 2) ? ModeCustom : ModeW'($urandom_range(0, 2));
		case ($urandom_range(0, 3))
			0: offset = random_coord();
			1: offset = 0;
			default: offset = $urandom();
		endcase
		for (int i = 0; i < 3; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				nrm[i] = NormW'($urandom());
			end else begin
				nrm[i] = NormW'($urandom_range(0, 32768) - 16384);
			end
		end
		case ($urandom_range(0, 5))
			0: total = 0;
			1: total = IdxW'(MaxVertices);
			2: total = '1;
			default: total = IdxW'($urandom_range(0, 131071));
		endcase
		configure(mode, offset, nrm[0], nrm[1], nrm[2], 1'($urandom_range(0, 1)), total);
	endtask

	task automatic test_reset_defaults();
		send_item(vertex(32'sh00018000, 32'shfffe0000, 32'sh00030000));
		send_item(vertex(32'sh80000000, 32'sh80000000, 32'sh80000000));
		send_item(vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
		send_item(face(16'h0000, 16'h0000, 16'h0000));
		send_item(face(16'hffff, 16'hffff, 16'hffff));
	endtask

	task automatic test_coordinate_planes();
		configure(ModeXz, 0, 0, 0, NormUnit, 1'b1, 0);
		send_item(vertex(32'sh00010000, 32'sh80000000, 32'sh7fffffff));
		configure(ModeYz, 0, 0, 0, NormUnit, 1'b1, 0);
		send_item(vertex(32'sh80000000, 32'sh00000005, 32'shfffffff9));
		configure(ModeXy, 0, 0, 0, NormUnit, 1'b0, 0);
		send_item(vertex(32'sh00000000, 32'sh00000000, 32'shffffffff));
		send_item(vertex(32'sh12345678, 32'shedcba987, 32'sh80000000));
	endtask

	task automatic test_custom_plane();
		configure(ModeCustom, 32'sh00010000, NormUnit, 0, 0, 1'b1, 0);
		send_item(vertex(32'sh00030000, 32'sh00010000, 32'shffff0000));
		configure(ModeCustom, 32'sh7fffffff, 0, 0, 0, 1'b1, 0);
		send_item(vertex(32'sh0badcafe, 32'shc0ffee00, 32'sh80000001));
		configure(ModeCustom, 32'sh80000000, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1, 0);
		send_item(vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
		send_item(vertex(32'sh80000000, 32'sh7fffffff, 32'sh80000000));
		configure(ModeCustom, 32'shffff8000, 16'shc000, 16'sh2d41, 16'sh2d41, 1'b0, 0);
		send_item(vertex(32'sh00028000, 32'shfffd0000, 32'sh00001234));
	endtask

	task automatic test_face_offsets();
		configure(ModeXy, 0, 0, 0, NormUnit, 1'b1, 17'd65536);
		send_item(face(16'd0, 16'd1, 16'd2));
		send_item(face(16'hffff, 16'hffff, 16'hffff));
		configure(ModeXy, 0, 0, 0, NormUnit, 1'b1, 17'h1ffff);
		send_item(face(16'hffff, 16'h0000, 16'd1234));
		configure(ModeXy, 0, 0, 0, NormUnit, 1'b0, 17'h1ffff);
		send_item(face(16'd10, 16'd20, 16'd30));
		send_item(vertex(32'sh00010000, 32'sh00020000, 32'sh00030000));
	endtask

	task automatic test_unknown_register();
		wait_idle();
		write_reg(CfgUnused, 32'hffffffff);
		send_item(vertex(32'sh00040000, 32'shfff00000, 32'sh00000001));
		send_item(face(16'd7, 16'd8, 16'd9));
	endtask

	task automatic test_random_mix();
		for (int phase = 0; phase < 6; phase++) begin
			random_plane();
			repeat (100) send_item(random_item());
		end
	endtask

	task automatic test_backpressure();
		random_plane();
		// stall the sink long enough to fill the pipeline
		sink_hold_req = 1'b1;
		repeat (60) send_item(random_item());
	endtask

	task automatic test_streaming();
		idle_on = 1'b0;
		random_plane();
		repeat (100) send_item(random_item());
	endtask

	initial begin
		arst_n            <= 1'b0;
		item_bus.valid    <= 1'b0;
		item_bus.op       <= OpVertex;
		item_bus.coord_x  <= '0;
		item_bus.coord_y  <= '0;
		item_bus.coord_z  <= '0;
		item_bus.corner_a <= '0;
		item_bus.corner_b <= '0;
		item_bus.corner_c <= '0;
		cfg_bus.valid     <= 1'b0;
		cfg_bus.idx       <= CfgPlaneMode;
		cfg_bus.data      <= '0;
		idle_on = 1'b1;
		sink_hold_req = 1'b0;
		fail_count = 0;
		plane_cfg.plane_mode = ModeXy;
		plane_cfg.plane_offset = '0;
		plane_cfg.normal_x = '0;
		plane_cfg.normal_y = '0;
		plane_cfg.normal_z = NormUnit;
		plane_cfg.emit_both = 1'b1;
		plane_cfg.vertex_total = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_coordinate_planes();
		test_custom_plane();
		test_face_offsets();
		test_unknown_register();
		test_random_mix();
		test_backpressure();
		test_streaming();

		wait_idle();
		repeat (12) @(posedge clk);
		if (fail_count == 0) begin
			$display("mesh_plane_mirror regression: pass");
		end else begin
			$display("mesh_plane_mirror regression: fail");
		end
		$finish;
	end

endmodule
